// ----- rtl/octet_counted_frame_deframer_unit_macros.svh -----
// Assertion macros for the deframer top level.
// Each macro checks an implication on the rising edge of clk, with rst masking the check.
`ifndef OCTET_COUNTED_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define OCTET_COUNTED_FRAME_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define OCFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");
// Next-cycle implication.
`define OCFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");
`else
`define OCFD_ASSERT_NOW(label, ante, cons)
`define OCFD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- rtl/ocfd_pkg.sv -----
package ocfd_pkg;

  // Width of the header length and of the payload byte count.
  localparam int ACC_W = 34;
  localparam int CFG_W = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Result status codes.
  localparam logic [1:0] ST_BYTE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_HDR_ERR = 2'd2;
  localparam logic [1:0] ST_OVR_ERR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_SIZE = 2'd0;
  localparam logic [1:0] CFG_TRIM     = 2'd1;
  localparam logic [1:0] CFG_CHUNK    = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRIM,
    PH_DISCARD,
    PH_HALTED
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_size;
    logic             trim_en;
    logic [CFG_W-1:0] chunk;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
    logic       trunc;
  } res_t;

endpackage

// ----- rtl/ocfd_front.sv -----
module ocfd_front #(
  parameter int MAX_LENGTH_DIGITS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  ocfd_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            push,
  output ocfd_pkg::res_t  push_data
);
  import ocfd_pkg::*;

  localparam int DCW = $clog2(MAX_LENGTH_DIGITS + 1);

  phase_t           phase, phase_next;
  logic [ACC_W-1:0] len_acc, len_acc_next;
  logic [DCW-1:0]   digit_count, digit_count_next;
  logic [ACC_W-1:0] bytes_rem, bytes_rem_next;
  logic [CFG_W-1:0] deliver_rem, deliver_rem_next;

  logic             accept;
  logic             is_digit;
  logic [7:0]       digit_off;
  logic [ACC_W-1:0] acc_step;
  logic             len_over;
  logic             chunk_lt;
  logic [CFG_W-1:0] deliver_init;
  logic [ACC_W-1:0] bytes_dec;
  logic [CFG_W-1:0] deliver_dec;

  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign digit_off = in_byte - CH_ZERO;
  // Length times ten plus the new digit, wrapping at the accumulator width.
  assign acc_step  = (len_acc << 3) + (len_acc << 1) + ACC_W'(digit_off[3:0]);
  assign len_over  = len_acc > ACC_W'(cfg.max_size);
  assign chunk_lt  = ACC_W'(cfg.chunk) < len_acc;
  assign deliver_init = chunk_lt ? cfg.chunk : len_acc[CFG_W-1:0];
  assign bytes_dec    = bytes_rem - ACC_W'(1);
  assign deliver_dec  = deliver_rem - CFG_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      len_acc     <= '0;
      digit_count <= '0;
      bytes_rem   <= '0;
      deliver_rem <= '0;
    end else begin
      phase       <= phase_next;
      len_acc     <= len_acc_next;
      digit_count <= digit_count_next;
      bytes_rem   <= bytes_rem_next;
      deliver_rem <= deliver_rem_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    len_acc_next     = len_acc;
    digit_count_next = digit_count;
    bytes_rem_next   = bytes_rem;
    deliver_rem_next = deliver_rem;
    push             = 1'b0;
    push_data        = '{data: 8'h00, status: ST_BYTE, last: 1'b0, trunc: 1'b0};
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          if (is_digit && (digit_count < DCW'(MAX_LENGTH_DIGITS))) begin
            len_acc_next     = acc_step;
            digit_count_next = digit_count + DCW'(1);
          end else if (in_byte == CH_SPACE) begin
            len_acc_next     = '0;
            digit_count_next = '0;
            if (len_over) begin
              if (!cfg.trim_en) begin
                phase_next       = PH_HALTED;
                push             = 1'b1;
                push_data.status = ST_OVR_ERR;
              end else begin
                // The full length is kept and counted down alongside the
                // delivered bytes, so what is left afterwards is the discard.
                deliver_rem_next = deliver_init;
                bytes_rem_next   = len_acc;
                phase_next       = (cfg.chunk == '0) ? PH_DISCARD : PH_TRIM;
              end
            end else if (len_acc == '0) begin
              push             = 1'b1;
              push_data.status = ST_EMPTY;
              push_data.last   = 1'b1;
            end else begin
              bytes_rem_next = len_acc;
              phase_next     = PH_PAYLOAD;
            end
          end else begin
            phase_next       = PH_HALTED;
            push             = 1'b1;
            push_data.status = ST_HDR_ERR;
          end
        end
        PH_PAYLOAD: begin
          bytes_rem_next = bytes_dec;
          push           = 1'b1;
          push_data.data = in_byte;
          push_data.last = (bytes_dec == '0);
          if (bytes_dec == '0) begin
            phase_next = PH_HEADER;
          end
        end
        PH_TRIM: begin
          deliver_rem_next = deliver_dec;
          bytes_rem_next   = bytes_dec;
          push             = 1'b1;
          push_data.data   = in_byte;
          push_data.trunc  = 1'b1;
          push_data.last   = (deliver_dec == '0);
          if (deliver_dec == '0) begin
            phase_next = (bytes_dec != '0) ? PH_DISCARD : PH_HEADER;
          end
        end
        PH_DISCARD: begin
          bytes_rem_next = bytes_dec;
          if (bytes_dec == '0) begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_HALTED;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ocfd_queue.sv -----
module ocfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ocfd_pkg::res_t  push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output ocfd_pkg::res_t  pop_data
);
  import ocfd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  res_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/ocfd_back.sv -----
module ocfd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  ocfd_pkg::res_t  q_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      status,
  output logic            last_of_message,
  output logic            truncated
);
  import ocfd_pkg::*;

  res_t out_reg;

  // Refill the output register whenever it is empty or its word is taken.
  assign pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= q_data;
    end
  end

  assign out_byte        = out_reg.data;
  assign status          = out_reg.status;
  assign last_of_message = out_reg.last;
  assign truncated       = out_reg.trunc;

endmodule

// ----- rtl/octet_counted_frame_deframer_unit.sv -----
// Octet-counted frame deframer.
// The input channel (in_valid, in_stall, in_byte) carries one raw stream byte per word. Each
// frame is a decimal length of up to MAX_LENGTH_DIGITS digits, a space, then that many bytes.
// The output channel (out_valid, out_stall and the result fields) carries one result word per
// payload byte, one per zero-length frame and one per error; header digits, the space and
// discarded bytes of a trimmed frame give no word. After a header or oversize error the
// block keeps taking bytes but returns nothing until reset.
// The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes max_message_size,
// trim_enable and chunk_size at indexes 0, 1 and 2; cfg_ready is always high. Limits are
// sampled when a header's space arrives, so writes are best made between frames.
// Throughput is one byte per cycle while in_stall is low. The edge that takes a byte writes
// its result word into the result queue; the word then moves into the output register once
// that register is empty or its word is taken.
// The parser holds only narrow per-byte state: a times-ten add on the length and one counter
// decrement per payload byte (two while a frame is trimmed).
// When the receiver stalls, the output register holds its word and the queue fills; in_stall
// rises once the queue is full, and from then on the input waits as long as the receiver does.
// Synchronous reset returns the parser to header phase, empties the queue and output
// register, and restores the register defaults (65536, off, 65536). No clearing pass.
module octet_counted_frame_deframer_unit #(
  parameter int MAX_LENGTH_DIGITS = 10,
  parameter int QUEUE_DEPTH       = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  status,
  output logic        last_of_message,
  output logic        truncated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ocfd_pkg::*;

  `include "octet_counted_frame_deframer_unit_macros.svh"

  cfg_t cfg;
  logic front_push;
  res_t front_data;
  logic q_full;
  logic q_pop;
  logic q_valid;
  res_t q_data;

  // Configuration registers. Writes to an unused index are taken and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_size <= CFG_W'(65536);
      cfg.trim_en  <= 1'b0;
      cfg.chunk    <= CFG_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SIZE: cfg.max_size <= cfg_data;
        CFG_TRIM:     cfg.trim_en  <= cfg_data[0];
        CFG_CHUNK:    cfg.chunk    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: header parsing, length checks and per-byte classification.
  ocfd_front #(
    .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (front_push),
    .push_data (front_data)
  );

  // Result queue that decouples the parser from the output stall.
  ocfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // Back end: the output register that faces the receiver.
  ocfd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .status          (status),
    .last_of_message (last_of_message),
    .truncated       (truncated)
  );

  // The parser must never write into a full queue.
  `OCFD_ASSERT_NOW(a_no_overflow, q_full, !front_push)
  // An error halts the parser, so it is never followed by another result.
  `OCFD_ASSERT_NEXT(a_halt_after_error, front_push && (front_data.status == ST_HDR_ERR ||
      front_data.status == ST_OVR_ERR), !front_push)
  // Error words carry no byte and no marks (empty-message words carry no byte either, but are not checked here).
  `OCFD_ASSERT_NOW(a_error_fields, out_valid && (status == ST_HDR_ERR ||
      status == ST_OVR_ERR), !last_of_message && !truncated && out_byte == 8'h00)

endmodule
